@@ rtl/gbc_pkg.sv @@
package gbc_pkg;

	localparam int unsigned NUM_KEYS   = 8;
	localparam int unsigned NUM_ROUNDS = 32;
	localparam int unsigned KEY_IDX_W  = 3;
	localparam int unsigned ROUND_W    = 5;

	localparam logic [ROUND_W-1:0] LAST_ROUND = 5'd31;

	// operation selector carried in tuser
	localparam logic FUNC_ENCRYPT = 1'b0;
	localparam logic FUNC_DECRYPT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} gbc_state_t;

	typedef struct packed {
		logic                 load;      // take a new block into the working halves
		logic                 step;      // run one round
		logic [ROUND_W-1:0]   round;     // round being run
		logic                 out_run;   // load result register from this round's result
		logic                 out_hold;  // load result register from the working halves
	} gbc_cmd_t;

	// S-box k acts on nibble k, nibble 0 least significant
	localparam logic [3:0] SBOX [8][16] = '{
		'{4'd1, 4'd15, 4'd13, 4'd0, 4'd5, 4'd7, 4'd10, 4'd4,
		  4'd9, 4'd2, 4'd3, 4'd14, 4'd6, 4'd11, 4'd8, 4'd2},
		'{4'd13, 4'd11, 4'd4, 4'd1, 4'd3, 4'd15, 4'd5, 4'd9,
		  4'd0, 4'd10, 4'd14, 4'd7, 4'd6, 4'd8, 4'd2, 4'd12},
		'{4'd4, 4'd11, 4'd10, 4'd0, 4'd7, 4'd2, 4'd1, 4'd13,
		  4'd3, 4'd6, 4'd8, 4'd5, 4'd9, 4'd12, 4'd15, 4'd14},
		'{4'd6, 4'd12, 4'd7, 4'd1, 4'd5, 4'd15, 4'd13, 4'd8,
		  4'd4, 4'd10, 4'd9, 4'd14, 4'd0, 4'd3, 4'd11, 4'd2},
		'{4'd7, 4'd13, 4'd10, 4'd1, 4'd0, 4'd8, 4'd9, 4'd15,
		  4'd14, 4'd4, 4'd6, 4'd12, 4'd11, 4'd2, 4'd5, 4'd3},
		'{4'd5, 4'd8, 4'd1, 4'd13, 4'd10, 4'd3, 4'd4, 4'd2,
		  4'd14, 4'd15, 4'd12, 4'd7, 4'd6, 4'd0, 4'd9, 4'd11},
		'{4'd14, 4'd11, 4'd4, 4'd12, 4'd6, 4'd13, 4'd15, 4'd10,
		  4'd2, 4'd3, 4'd8, 4'd1, 4'd0, 4'd7, 4'd5, 4'd9},
		'{4'd4, 4'd10, 4'd9, 4'd2, 4'd13, 4'd8, 4'd0, 4'd14,
		  4'd6, 4'd11, 4'd1, 4'd12, 4'd7, 4'd15, 4'd5, 4'd3}
	};

	// substitution then rotate left by 11
	function automatic logic [31:0] gbc_f(input logic [31:0] x);
		logic [31:0] y;
		y = '0;
		for (int k = 0; k < 8; k++) begin
			y[4*k +: 4] = SBOX[k][x[4*k +: 4]];
		end
		return {y[20:0], y[31:21]};
	endfunction

endpackage

@@ rtl/gbc_ctrl.sv @@
module gbc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output gbc_pkg::gbc_cmd_t cmd
);
	import gbc_pkg::*;

	gbc_state_t         state_q, state_d;
	logic [ROUND_W-1:0] round_q, round_d;
	logic               out_valid_q, out_valid_d;
	logic               out_free;
	logic               last;
	logic               accept;

	assign out_free  = !out_valid_q || out_ready;
	assign last      = (round_q == LAST_ROUND);
	assign out_valid = out_valid_q;

	// outputs
	always_comb begin
		cmd          = '0;
		cmd.round    = round_q;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_RUN: begin
				cmd.step    = 1'b1;
				cmd.out_run = last && out_free;
				// next block may enter as the finished one moves to the result register
				in_ready    = last && out_free;
			end
			ST_WAIT: begin
				cmd.out_hold = out_free;
				in_ready     = 1'b0;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		accept   = in_valid && in_ready;
		cmd.load = accept;
	end

	// next state
	always_comb begin
		state_d = state_q;
		round_d = round_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_RUN;
					round_d = '0;
				end
			end
			ST_RUN: begin
				round_d = round_q + 1'b1;
				if (last) begin
					if (accept) begin
						state_d = ST_RUN;
						round_d = '0;
					end else if (out_free) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_WAIT;
					end
				end
			end
			ST_WAIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		out_valid_d = cmd.out_run || cmd.out_hold || (out_valid_q && !out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			round_q     <= round_d;
			out_valid_q <= out_valid_d;
		end
	end

	a_wait_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT |-> out_valid_q)
		else $error("waiting for output with result register empty");

	a_run_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && in_ready) |-> (last && out_free))
		else $error("block taken before current block finished");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_RUN && round_q == '0))
		else $error("accepted block did not start at round zero");

	a_finish_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_run || cmd.out_hold) |=> out_valid_q)
		else $error("result register load lost");

endmodule

@@ rtl/gbc_datapath.sv @@
module gbc_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gbc_pkg::gbc_cmd_t            cmd,
	input  logic                         func,
	input  logic [31:0]                  half_a_in,
	input  logic [31:0]                  half_b_in,
	input  logic                         key_we,
	input  logic [gbc_pkg::KEY_IDX_W-1:0] key_idx,
	input  logic [31:0]                  key_data,
	output logic [31:0]                  half_a_out,
	output logic [31:0]                  half_b_out
);
	import gbc_pkg::*;

	logic [31:0]          key_q [NUM_KEYS];
	logic [31:0]          n1_q, n2_q;
	logic                 decrypt_q;
	logic [31:0]          out_a_q, out_b_q;
	logic                 fwd;
	logic [KEY_IDX_W-1:0] ridx;
	logic [31:0]          rkey;
	logic [31:0]          src;
	logic [31:0]          fval;
	logic [31:0]          n1_d, n2_d;

	// forward order for the first 24 rounds (encrypt) or the first 8 (decrypt)
	always_comb begin
		if (decrypt_q == FUNC_DECRYPT) begin
			fwd = (cmd.round[4:3] == 2'd0);
		end else begin
			fwd = (cmd.round[4:3] != 2'd3);
		end
		ridx = fwd ? cmd.round[2:0] : ~cmd.round[2:0];
		rkey = key_q[ridx];
		// even rounds feed N1 into N2, odd rounds N2 into N1
		src  = cmd.round[0] ? n2_q : n1_q;
		fval = gbc_f(src + rkey);
		n1_d = n1_q;
		n2_d = n2_q;
		if (cmd.round[0]) begin
			n1_d = n1_q ^ fval;
		end else begin
			n2_d = n2_q ^ fval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				key_q[i] <= '0;
			end
		end else if (key_we) begin
			key_q[key_idx] <= key_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n1_q      <= half_a_in;
			n2_q      <= half_b_in;
			decrypt_q <= func;
		end else if (cmd.step) begin
			n1_q <= n1_d;
			n2_q <= n2_d;
		end
		if (cmd.out_run) begin
			out_a_q <= n2_d;
			out_b_q <= n1_d;
		end else if (cmd.out_hold) begin
			out_a_q <= n2_q;
			out_b_q <= n1_q;
		end
	end

	assign half_a_out = out_a_q;
	assign half_b_out = out_b_q;

endmodule

@@ rtl/gost_block_cipher_top.sv @@
// GOST 28147-89 block cipher engine (ECB core). One 64-bit block enters per
// s_axis word: tdata[31:0] is the first half (N1), tdata[63:32] the second
// half (N2), tuser[0] selects encrypt (0) or decrypt (1). The 32 Feistel
// rounds run one per clock through a single round unit (key add, eight
// S-boxes, rotate by 11, XOR), stepped by the round counter. The next
// block is accepted in the cycle the last round completes, provided the
// result register is free. The result word carries final N2 in tdata[31:0]
// and final N1 in tdata[63:32] and waits in its own register; a stalled
// master side holds at most one finished block in the working registers.
// Subkeys 0..7 are written through the cfg port (index = subkey number,
// always ready) and reset to zero; write them only while no block is in
// flight. No state carries over between blocks.
module gost_block_cipher_top (
	input  logic        clk,
	input  logic        arst_n,
	// input block
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [31:0] half_a_in, [63:32] half_b_in
	input  logic        s_axis_tuser,   // [0] func
	// result block
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] half_a_out, [63:32] half_b_out
	// subkey writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import gbc_pkg::*;

	gbc_cmd_t    cmd;
	logic [31:0] half_a_out;
	logic [31:0] half_b_out;

	assign cfg_ready = 1'b1;

	gbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	gbc_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.func       (s_axis_tuser),
		.half_a_in  (s_axis_tdata[31:0]),
		.half_b_in  (s_axis_tdata[63:32]),
		.key_we     (cfg_valid && cfg_ready),
		.key_idx    (cfg_index),
		.key_data   (cfg_data),
		.half_a_out (half_a_out),
		.half_b_out (half_b_out)
	);

	assign m_axis_tdata = {half_b_out, half_a_out};

endmodule

@@ tb/sv/gbc_checker.sv @@
`timescale 1ns / 1ps

module gbc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [31:0] half_a_in, [63:32] half_b_in
	input  logic        s_axis_tuser,   // [0] func
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,   // [31:0] half_a_out, [63:32] half_b_out
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          checked
);

	import gbc_pkg::*;

	typedef struct packed {
		logic [31:0] half_b;
		logic [31:0] half_a;
	} half_pair_t;

	logic [31:0] key_words [NUM_KEYS];
	half_pair_t  expected_blocks [$];

	function automatic logic [31:0] sub_rotate(input logic [31:0] x);
		logic [31:0] y;
		for (int k = 0; k < 8; k++)
			y[4*k +: 4] = SBOX[k][x[4*k +: 4]];
		return (y << 11) | (y >> 21);
	endfunction

	// full 32-round network; result halves leave swapped
	function automatic half_pair_t cipher_block(input logic func, input logic [31:0] n1,
			input logic [31:0] n2);
		half_pair_t  res;
		int          fwd_rounds;
		logic [31:0] k;
		fwd_rounds = (func == FUNC_DECRYPT) ? 8 : 24;
		for (int r = 0; r < NUM_ROUNDS; r++) begin
			k = (r < fwd_rounds) ? key_words[r % 8] : key_words[7 - (r % 8)];
			if (r % 2 == 0)
				n2 ^= sub_rotate(n1 + k);
			else
				n1 ^= sub_rotate(n2 + k);
		end
		res.half_a = n2;
		res.half_b = n1;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		half_pair_t exp_w;
		half_pair_t got_w;
		int         err_n;
		if (!arst_n) begin
			foreach (key_words[i]) key_words[i] <= '0;
			expected_blocks.delete();
			errors  <= 0;
			checked <= 0;
			pending <= 0;
		end else begin
			err_n = 0;
			if (cfg_valid && cfg_ready)
				key_words[cfg_index] <= cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				expected_blocks.push_back(cipher_block(s_axis_tuser, s_axis_tdata[31:0],
					s_axis_tdata[63:32]));
			if (m_axis_tvalid && m_axis_tready) begin
				got_w = m_axis_tdata;
				if (expected_blocks.size() == 0) begin
					$error("result word %h with no block outstanding", m_axis_tdata);
					err_n++;
				end else begin
					exp_w = expected_blocks.pop_front();
					checked <= checked + 1;
					if (got_w.half_a !== exp_w.half_a) begin
						$error("half_a_out: expected %h, actual %h", exp_w.half_a, got_w.half_a);
						err_n++;
					end
					if (got_w.half_b !== exp_w.half_b) begin
						$error("half_b_out: expected %h, actual %h", exp_w.half_b, got_w.half_b);
						err_n++;
					end
				end
			end
			errors  <= errors + err_n;
			pending <= expected_blocks.size();
		end
	end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

	import gbc_pkg::*;

	// cycles with no handshake on any channel before the run is declared hung;
	// a block needs all its rounds plus sender gap and receiver stall
	localparam int HANG_LIMIT   = 4000;
	localparam int ITEMS_PER_KEY = 110;
	localparam int KEY_SETS      = 5;
	localparam int DRAIN_CYCLES  = 40;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata  = '0;    // [31:0] half_a_in, [63:32] half_b_in
	logic        s_axis_tuser  = 1'b0;  // [0] func
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;          // [31:0] half_a_out, [63:32] half_b_out
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index     = '0;
	logic [31:0] cfg_data      = '0;

	int errors;
	int pending;
	int checked;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int quiet_cycles = 0;
	int key_loads    = 0;

	gost_block_cipher_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// predictor and scoreboard sit beside the block, watching all three channels
	gbc_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending),
		.checked       (checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver backpressure; all drives happen on the falling edge
	always @(negedge clk)
		m_axis_tready = ($urandom_range(99) >= snk_idle_pct);

	// hang detector: any accepted word on any channel resets the count
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles, %0d blocks outstanding",
				HANG_LIMIT, pending);
			$display("Test completed with failures");
			$finish;
		end
	end

	// one subkey write; called and returns on a falling edge
	task automatic write_subkey(input logic [2:0] idx, input logic [31:0] word);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = word;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
			input logic [31:0] k2, input logic [31:0] k3, input logic [31:0] k4,
			input logic [31:0] k5, input logic [31:0] k6, input logic [31:0] k7);
		write_subkey(3'd0, k0);
		write_subkey(3'd1, k1);
		write_subkey(3'd2, k2);
		write_subkey(3'd3, k3);
		write_subkey(3'd4, k4);
		write_subkey(3'd5, k5);
		write_subkey(3'd6, k6);
		write_subkey(3'd7, k7);
		key_loads++;
	endtask

	// send one block; valid stays high into the next call unless it idles
	task automatic send_block(input logic func, input logic [31:0] a, input logic [31:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {b, a};
		s_axis_tuser  = func;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// hold the sender until every block has come back; subkeys only change after it
	task automatic drain_blocks();
		s_axis_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// biased toward the all-zero / all-one halves and single bits
	function automatic logic [31:0] pick_half();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return 32'h1 << $urandom_range(31);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] pick_key_word(input int kind);
		case (kind)
			0:       return '0;
			1:       return '1;
			2:       return ~(32'h1 << $urandom_range(31));
			default: return $urandom();
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset key (all zero), both operations, extreme halves
		src_idle_pct = 23;
		snk_idle_pct = 66;
		send_block(FUNC_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
		send_block(FUNC_DECRYPT, 32'h0000_0000, 32'h0000_0000);
		send_block(FUNC_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_block(FUNC_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain_blocks();

		// all-ones key: carry out of the key add whenever the added half is nonzero
		load_key('1, '1, '1, '1, '1, '1, '1, '1);
		send_block(FUNC_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_block(FUNC_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
		send_block(FUNC_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
		send_block(FUNC_DECRYPT, 32'h0000_0001, 32'h8000_0000);
		send_block(FUNC_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain_blocks();

		// distinct words per subkey, so any slip in key order shows up
		load_key(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210,
			32'hA5A5_5A5A, 32'h0F0F_F0F0, 32'h8000_0001, 32'h7FFF_FFFE);
		send_block(FUNC_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
		send_block(FUNC_DECRYPT, 32'h0000_0000, 32'h0000_0000);
		send_block(FUNC_ENCRYPT, 32'hDEAD_BEEF, 32'h0BAD_F00D);
		send_block(FUNC_DECRYPT, 32'hDEAD_BEEF, 32'h0BAD_F00D);
		send_block(FUNC_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
		send_block(FUNC_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
		drain_blocks();

		// random blocks across three idling regimes, several keys each
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin src_idle_pct = 23; snk_idle_pct = 66; end
				1: begin src_idle_pct = 66; snk_idle_pct = 23; end
				default: begin src_idle_pct = 0; snk_idle_pct = 0; end
			endcase
			for (int ks = 0; ks < KEY_SETS; ks++) begin
				drain_blocks();
				load_key(pick_key_word(ks), pick_key_word(ks), pick_key_word(ks),
					pick_key_word(ks), pick_key_word(ks), pick_key_word(ks),
					pick_key_word(ks), pick_key_word(ks));
				repeat (ITEMS_PER_KEY)
					send_block(logic'($urandom_range(1)), pick_half(), pick_half());
			end
		end

		drain_blocks();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d result blocks, encrypt and decrypt, under %0d subkey loads",
			checked, key_loads);
		$display("idling: sender 23/receiver 66, sender 66/receiver 23, then none");
		if (errors == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
